@@ rtl/rdg_pkg.sv @@
// Shared definitions for the readability grade scanner.
// Holds default sizes, fixed-point constants, controller states and the
// command/status structs that join the controller and the datapath.
`default_nettype none

package rdg_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int FIELD_W        = 24;
	localparam int SYL_W          = 16;
	localparam int SCORE_W        = 32;

	// Q8 fixed-point terms of the grade formula
	localparam int OFFSET_Q8 = -3991;
	localparam int A_MUL     = 9984;
	localparam int B_MUL     = 302080;
	localparam int ROUND_ADD = 50;
	localparam int SCALE     = 100;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_Y     = 8'h79;

	typedef enum logic [2:0] {
		S_SCAN,
		S_START_A,
		S_WAIT_A,
		S_START_B,
		S_WAIT_B,
		S_SUM
	} rdg_state_t;

	typedef struct packed {
		logic scan_en;
		logic start_div;
		logic sel_b;
		logic capture_a;
		logic load_out;
		logic clear_counts;
	} rdg_cmd_t;

	typedef struct packed {
		logic fault;
		logic div_done;
	} rdg_status_t;

endpackage

`default_nettype wire

@@ rtl/rdg_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; sizes come from the datapath.
`default_nettype none

module rdg_div #(
	parameter int NUM_W = 44,
	parameter int DEN_W = 31
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quot
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           take;

	assign trial = {rem_q, q_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = (trial >= {1'b0, den_q});
	assign done  = busy_q && (cnt_q == CNT_W'(NUM_W - 1));
	assign quot  = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			q_q   <= {q_q[NUM_W-2:0], take};
			rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ rtl/rdg_ctrl.sv @@
// Controller state machine: byte acceptance, division sequencing, result hold.
// Depends on rdg_pkg for states and command/status structs.
`default_nettype none

module rdg_ctrl
	import rdg_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic         end_of_text,
	output logic              in_stall,
	output logic              out_valid,
	input  wire logic         out_stall,
	input  wire rdg_status_t  status,
	output rdg_cmd_t          cmd
);

	rdg_state_t state_q, state_n;
	logic       out_valid_q;
	logic       in_accept;

	// stall outside S_SCAN, and hold the final byte back while the previous result is still waiting
	assign in_stall  = (state_q != S_SCAN) || (end_of_text && out_valid_q);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_SCAN:    if (in_accept && end_of_text) state_n = S_START_A;
			S_START_A: state_n = status.fault ? S_SUM : S_WAIT_A;
			S_WAIT_A:  if (status.div_done) state_n = S_START_B;
			S_START_B: state_n = S_WAIT_B;
			S_WAIT_B:  if (status.div_done) state_n = S_SUM;
			S_SUM:     state_n = S_SCAN;
			default:   state_n = S_SCAN;
		endcase
	end

	always_comb begin
		cmd              = '0;
		cmd.scan_en      = in_accept;
		case (state_q)
			S_START_A: cmd.start_div = !status.fault;
			S_START_B: begin
				cmd.start_div = 1'b1;
				cmd.sel_b     = 1'b1;
				cmd.capture_a = 1'b1;
			end
			S_SUM: begin
				cmd.load_out     = 1'b1;
				cmd.clear_counts = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SCAN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_SUM) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/rdg_dp.sv @@
// Datapath: token scanner, saturating counters, grade arithmetic, result registers.
// Depends on rdg_pkg and instantiates rdg_div.
`default_nettype none

module rdg_dp
	import rdg_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     text_byte,
	input  wire logic           end_of_text,
	input  wire rdg_cmd_t       cmd,
	output rdg_status_t         status,
	output logic [SCORE_W-1:0]  grade_score,
	output logic [FIELD_W-1:0]  word_total,
	output logic [FIELD_W-1:0]  sentence_total,
	output logic [FIELD_W-1:0]  syllable_total,
	output logic                divide_fault
);

	localparam int NUM_W = COUNT_BITS + 20;
	localparam int DEN_W = COUNT_BITS + 7;
	localparam int SUM_W = (COUNT_BITS > SYL_W ? COUNT_BITS : SYL_W) + 1;
	localparam int CAP_W = COUNT_BITS > FIELD_W ? COUNT_BITS : FIELD_W;
	localparam int SC_W  = (NUM_W + 2) > (SCORE_W + 1) ? (NUM_W + 2) : (SCORE_W + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [SYL_W-1:0]      SYL_MAX   = '1;
	localparam logic [FIELD_W-1:0]    FIELD_MAX = '1;
	localparam logic signed [SC_W-1:0] OFF_Q8  = SC_W'(OFFSET_Q8);
	localparam logic signed [SC_W-1:0] HI_LIM  = SC_W'(2147483647);
	localparam logic signed [SC_W-1:0] LO_LIM  = -SC_W'(64'sd2147483648);

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_word_byte(input logic [7:0] c);
		return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == 8'h5F || c == 8'h27;
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_vowel(input logic [7:0] c);
		return c == 8'h61 || c == CH_E || c == 8'h69 || c == 8'h6F || c == 8'h75
			|| c == CH_Y;
	endfunction

	function automatic logic [FIELD_W-1:0] cap(input logic [COUNT_BITS-1:0] v);
		logic [CAP_W-1:0] ext;
		ext = CAP_W'(v);
		return (ext > CAP_W'(FIELD_MAX)) ? FIELD_MAX : ext[FIELD_W-1:0];
	endfunction

	// token state
	logic             inside_q;
	logic             starts_q;
	logic [7:0]       prev_q;
	logic             slv_q;
	logic [1:0]       len_q;
	logic [SYL_W-1:0] ws_q;

	logic [COUNT_BITS-1:0] w_q, s_q, y_q;
	logic [NUM_W-1:0]      ta_q;

	logic [7:0]       f;
	logic             word, mark;
	logic             starts_n, slv_n;
	logic [1:0]       len_n;
	logic [SYL_W-1:0] ws_n;

	// state of the token being closed
	logic             close;
	logic             c_starts, c_slv;
	logic [1:0]       c_len;
	logic [7:0]       c_prev;
	logic [SYL_W-1:0] c_n;

	logic [SUM_W-1:0]      y_sum;
	logic [COUNT_BITS-1:0] w_n, s_n, y_n;

	assign f    = fold(text_byte);
	assign word = is_word_byte(text_byte);
	assign mark = text_byte == CH_DOT || text_byte == CH_QUEST || text_byte == CH_BANG;

	always_comb begin
		if (!inside_q) begin
			starts_n = is_letter(text_byte);
			len_n    = 2'd1;
			ws_n     = '0;
			slv_n    = 1'b0;
		end else begin
			starts_n = starts_q;
			ws_n     = ws_q;
			if (is_vowel(prev_q) && !is_vowel(f) && ws_q != SYL_MAX) begin
				ws_n = ws_q + 1'b1;
			end
			slv_n = is_vowel(prev_q);
			len_n = (len_q == 2'd3) ? len_q : len_q + 1'b1;
		end
	end

	always_comb begin
		close    = cmd.scan_en && (word ? end_of_text : inside_q);
		c_starts = word ? starts_n : starts_q;
		c_slv    = word ? slv_n : slv_q;
		c_len    = word ? len_n : len_q;
		c_prev   = word ? f : prev_q;
		c_n      = word ? ws_n : ws_q;
		// add a trailing vowel, or a silent-looking final e after a vowel
		if (c_prev != CH_E && is_vowel(c_prev) && c_n != SYL_MAX) begin
			c_n = c_n + 1'b1;
		end else if (c_len == 2'd3 && c_prev == CH_E && c_slv && c_n != SYL_MAX) begin
			c_n = c_n + 1'b1;
		end
		if (c_n == '0) begin
			c_n = SYL_W'(1);
		end
	end

	always_comb begin
		w_n   = w_q;
		y_n   = y_q;
		s_n   = s_q;
		y_sum = SUM_W'(y_q) + SUM_W'(c_n);
		if (close && c_starts) begin
			w_n = (w_q == COUNT_MAX) ? w_q : w_q + 1'b1;
			y_n = (y_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : y_sum[COUNT_BITS-1:0];
		end
		if (cmd.scan_en && !word && mark && s_q != COUNT_MAX) begin
			s_n = s_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			starts_q <= 1'b0;
			prev_q   <= '0;
			slv_q    <= 1'b0;
			len_q    <= '0;
			ws_q     <= '0;
			w_q      <= '0;
			s_q      <= '0;
			y_q      <= '0;
		end else begin
			if (cmd.scan_en) begin
				if (end_of_text) begin
					inside_q <= 1'b0;
					starts_q <= 1'b0;
					prev_q   <= '0;
					slv_q    <= 1'b0;
					len_q    <= '0;
					ws_q     <= '0;
				end else if (word) begin
					inside_q <= 1'b1;
					starts_q <= starts_n;
					prev_q   <= f;
					slv_q    <= slv_n;
					len_q    <= len_n;
					ws_q     <= ws_n;
				end else begin
					inside_q <= 1'b0;
				end
			end
			if (cmd.clear_counts) begin
				w_q <= '0;
				s_q <= '0;
				y_q <= '0;
			end else begin
				w_q <= w_n;
				s_q <= s_n;
				y_q <= y_n;
			end
		end
	end

	// division operands for the two grade terms
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [NUM_W-1:0] quot;
	logic             div_done;

	always_comb begin
		if (cmd.sel_b) begin
			div_num = NUM_W'(y_q) * NUM_W'(B_MUL) + NUM_W'(w_q) * NUM_W'(ROUND_ADD);
			div_den = DEN_W'(w_q) * DEN_W'(SCALE);
		end else begin
			div_num = NUM_W'(w_q) * NUM_W'(A_MUL) + NUM_W'(s_q) * NUM_W'(ROUND_ADD);
			div_den = DEN_W'(s_q) * DEN_W'(SCALE);
		end
	end

	rdg_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start_div),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (quot)
	);

	assign status.fault    = (w_q == '0) || (s_q == '0);
	assign status.div_done = div_done;

	logic signed [SC_W-1:0] score;

	assign score = $signed(SC_W'(ta_q)) + $signed(SC_W'(quot)) + OFF_Q8;

	always_ff @(posedge clk) begin
		if (cmd.capture_a) begin
			ta_q <= quot;
		end
		if (cmd.load_out) begin
			word_total     <= cap(w_q);
			sentence_total <= cap(s_q);
			syllable_total <= cap(y_q);
			divide_fault   <= status.fault;
			if (status.fault) begin
				grade_score <= '0;
			end else if (score > HI_LIM) begin
				grade_score <= HI_LIM[SCORE_W-1:0];
			end else if (score < LO_LIM) begin
				grade_score <= LO_LIM[SCORE_W-1:0];
			end else begin
				grade_score <= score[SCORE_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/readability_grade_text_scanner.sv @@
// Readability grade scanner, top level: controller plus datapath.
// Depends on rdg_pkg, rdg_ctrl, rdg_dp and rdg_div.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one text byte per transfer
//   with end_of_text marking the final byte. Ordinary bytes are scanned at
//   one per cycle while no division runs: words, sentence marks and
//   syllables are counted on the fly and no result is produced for them.
//   The final byte closes any open word, then two serial divisions form the
//   grade terms W/S and Y/W, one quotient bit per cycle in a shared divider.
//   The result reaches the output channel (out_valid / out_stall) through
//   the states S_START_A, S_WAIT_A, S_START_B, S_WAIT_B and S_SUM; with a zero
//   word or sentence count the divisions are skipped and S_START_A goes to S_SUM.
//   in_stall stays high while the divisions run.
//   The result sits in an output register: scanning of the next text goes
//   on while it waits, and only the next final byte is held back until the
//   receiver takes the pending result. A stalled result holds its value.
//   Reset (arst_n low) clears all counts, the open token and any pending
//   result; the block then accepts bytes at once.
`default_nettype none

module readability_grade_text_scanner
	import rdg_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         text_byte,
	input  wire logic               end_of_text,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [SCORE_W-1:0]      grade_score,
	output logic [FIELD_W-1:0]      word_total,
	output logic [FIELD_W-1:0]      sentence_total,
	output logic [FIELD_W-1:0]      syllable_total,
	output logic                    divide_fault
);

	rdg_cmd_t    cmd;
	rdg_status_t status;

	// sequence acceptance, the two divisions and the result hold
	rdg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.end_of_text(end_of_text),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// scan bytes, count, divide and register the result fields
	rdg_dp #(
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_byte     (text_byte),
		.end_of_text   (end_of_text),
		.cmd           (cmd),
		.status        (status),
		.grade_score   (grade_score),
		.word_total    (word_total),
		.sentence_total(sentence_total),
		.syllable_total(syllable_total),
		.divide_fault  (divide_fault)
	);

endmodule

`default_nettype wire
